// ===== sv/r12ub_pkg.sv =====
// Shared types and constants for the packed raw12 unpacker with peak and box statistics.
// Used by the channel interfaces and by raw12_unpack_with_peak_and_box_core.
// No dependencies.
package r12ub_pkg;

  // Frame size limits.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int PIX_W    = 16;
  localparam int GAIN_W   = 7;
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int PROD_W   = PIX_W + GAIN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [GAIN_W-1:0]  gain_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [PROD_W-1:0]  prod_t;

  // Largest pixel value after saturation.
  localparam pix_t PIX_MAX = '1;

  // Effective frame size bounds.
  localparam dim_t MIN_W_EFF = dim_t'(2);
  localparam dim_t MAX_W_EFF = dim_t'(MAX_WIDTH - (MAX_WIDTH % 2));
  localparam dim_t MIN_H_EFF = dim_t'(1);
  localparam dim_t MAX_H_EFF = dim_t'(MAX_HEIGHT);

  // Register reset values.
  localparam pix_t  RST_BLACK_LEVEL   = pix_t'(0);
  localparam gain_t RST_GAIN          = gain_t'(1);
  localparam pix_t  RST_THRESHOLD     = pix_t'(15000);
  localparam dim_t  RST_FRAME_WIDTH   = dim_t'(4056);
  localparam dim_t  RST_FRAME_HEIGHT  = dim_t'(3040);
  localparam dim_t  RST_BOX_ROW_LIMIT = dim_t'(3040);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLACK_LEVEL   = 3'd0,
    REG_GAIN          = 3'd1,
    REG_THRESHOLD     = 3'd2,
    REG_FRAME_WIDTH   = 3'd3,
    REG_FRAME_HEIGHT  = 3'd4,
    REG_BOX_ROW_LIMIT = 3'd5
  } cfg_reg_t;

endpackage

// ===== sv/r12ub_in_if.sv =====
// Input channel: one packed three-byte group carrying two 12-bit pixels per transaction.
// Depends on r12ub_pkg.
interface r12ub_in_if;
  import r12ub_pkg::*;

  logic  valid;
  logic  ready;
  byte_t packed_first;
  byte_t packed_second;
  byte_t packed_nibbles;

  modport source (output valid, output packed_first, output packed_second,
                  output packed_nibbles, input ready);
  modport sink   (input valid, input packed_first, input packed_second,
                  input packed_nibbles, output ready);
endinterface

// ===== sv/r12ub_out_if.sv =====
// Result channel: corrected pixel pair plus frame-end statistics per transaction.
// Depends on r12ub_pkg.
interface r12ub_out_if;
  import r12ub_pkg::*;

  logic   valid;
  logic   ready;
  pix_t   pixel_even;
  pix_t   pixel_odd;
  logic   frame_end;
  pix_t   peak_value;
  coord_t peak_col;
  coord_t peak_row;
  logic   box_seen;
  coord_t box_left;
  coord_t box_right;
  coord_t box_top;
  coord_t box_bottom;

  modport source (output valid, output pixel_even, output pixel_odd, output frame_end,
                  output peak_value, output peak_col, output peak_row, output box_seen,
                  output box_left, output box_right, output box_top, output box_bottom,
                  input ready);
  modport sink   (input valid, input pixel_even, input pixel_odd, input frame_end,
                  input peak_value, input peak_col, input peak_row, input box_seen,
                  input box_left, input box_right, input box_top, input box_bottom,
                  output ready);
endinterface

// ===== sv/raw12_unpack_with_peak_and_box_core.sv =====
// Packed raw12 unpacker with black level, gain, per-frame peak search and bounding box.
// Depends on r12ub_pkg, r12ub_in_if and r12ub_out_if.
//
// Channel  Direction  Handshake        Payload
// in_chan  in         valid / ready    packed_first, packed_second, packed_nibbles
// out_chan out        valid / ready    pixel pair, frame_end, peak and box statistics
// cfg_*    in         cfg_we only      cfg_index selects register, cfg_data value
//
// One transaction per cycle is sustained while out_chan is ready; each result passes
// through the pixel correction stage, then the statistics and output register.
// rst_n is synchronous and active low; it clears counters, statistics and both stages.
// While out_chan is stalled, the correction stage still holds one more transaction, so
// in_chan.ready drops only once both stages are full.
module raw12_unpack_with_peak_and_box_core (
  input  logic                         clk,
  input  logic                         rst_n,
  r12ub_in_if.sink                     in_chan,
  r12ub_out_if.source                  out_chan,
  input  logic                         cfg_we,
  input  logic [r12ub_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [r12ub_pkg::CFG_DATA_W-1:0] cfg_data
);
  import r12ub_pkg::*;

  // Configuration registers.
  pix_t  black_level_r;
  gain_t gain_r;
  pix_t  threshold_r;
  dim_t  frame_width_r;
  dim_t  frame_height_r;
  dim_t  box_row_limit_r;

  // Frame position counters.
  coord_t col_r, col_nxt;
  coord_t row_r, row_nxt;

  // Correction stage.
  logic   s1_valid_r;
  pix_t   s1_p1_r, s1_p2_r;
  coord_t s1_col_r, s1_row_r;
  logic   s1_last_r;
  logic   s1_in_box_r;

  // Statistics state.
  pix_t   peak_r;
  coord_t peak_col_r, peak_row_r;
  logic   box_flag_r;
  coord_t box_left_r, box_right_r, box_top_r, box_bottom_r;

  // Output register.
  logic   out_valid_r;
  pix_t   out_pixel_even_r, out_pixel_odd_r;
  logic   out_frame_end_r;
  pix_t   out_peak_value_r;
  coord_t out_peak_col_r, out_peak_row_r;
  logic   out_box_seen_r;
  coord_t out_box_left_r, out_box_right_r, out_box_top_r, out_box_bottom_r;

  logic in_take;
  logic out_free;
  logic s1_adv;

  // Pipeline handshake: the output register loads when empty or being drained.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_adv        = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_take       = in_chan.valid && in_chan.ready;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_level_r   <= RST_BLACK_LEVEL;
      gain_r          <= RST_GAIN;
      threshold_r     <= RST_THRESHOLD;
      frame_width_r   <= RST_FRAME_WIDTH;
      frame_height_r  <= RST_FRAME_HEIGHT;
      box_row_limit_r <= RST_BOX_ROW_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLACK_LEVEL:   black_level_r   <= cfg_data[PIX_W-1:0];
        REG_GAIN:          gain_r          <= cfg_data[GAIN_W-1:0];
        REG_THRESHOLD:     threshold_r     <= cfg_data[PIX_W-1:0];
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_data[DIM_W-1:0];
        REG_BOX_ROW_LIMIT: box_row_limit_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel assembly: high byte plus nibble, left-justified to 16 bits.
  pix_t raw1, raw2;
  assign raw1 = {in_chan.packed_first,  in_chan.packed_nibbles[3:0], 4'b0000};
  assign raw2 = {in_chan.packed_second, in_chan.packed_nibbles[7:4], 4'b0000};

  // Black level subtraction with clamp, gain, and saturation.
  pix_t  diff1, diff2;
  prod_t prod1, prod2;
  pix_t  corr1, corr2;
  always_comb begin
    diff1 = (raw1 > black_level_r) ? raw1 - black_level_r : '0;
    diff2 = (raw2 > black_level_r) ? raw2 - black_level_r : '0;
    prod1 = prod_t'(diff1) * prod_t'(gain_r);
    prod2 = prod_t'(diff2) * prod_t'(gain_r);
    corr1 = (prod1[PROD_W-1:PIX_W] != '0) ? PIX_MAX : prod1[PIX_W-1:0];
    corr2 = (prod2[PROD_W-1:PIX_W] != '0) ? PIX_MAX : prod2[PIX_W-1:0];
  end

  // Effective frame size and end-of-row and end-of-frame detection.
  dim_t w_even, w_eff, h_eff;
  logic last_row_item, last_item;
  always_comb begin
    w_even = {frame_width_r[DIM_W-1:1], 1'b0};
    if (w_even < MIN_W_EFF) begin
      w_eff = MIN_W_EFF;
    end else if (w_even > MAX_W_EFF) begin
      w_eff = MAX_W_EFF;
    end else begin
      w_eff = w_even;
    end
    if (frame_height_r < MIN_H_EFF) begin
      h_eff = MIN_H_EFF;
    end else if (frame_height_r > MAX_H_EFF) begin
      h_eff = MAX_H_EFF;
    end else begin
      h_eff = frame_height_r;
    end
    last_row_item = ({1'b0, col_r} + dim_t'(2)) >= w_eff;
    last_item     = last_row_item && (({1'b0, row_r} + dim_t'(1)) >= h_eff);
    if (last_row_item) begin
      col_nxt = '0;
      row_nxt = last_item ? '0 : row_r + coord_t'(1);
    end else begin
      col_nxt = col_r + coord_t'(2);
      row_nxt = row_r;
    end
  end

  // Position counters advance on each accepted input transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Correction stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
    if (in_take) begin
      s1_p1_r     <= corr1;
      s1_p2_r     <= corr2;
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      s1_last_r   <= last_item;
      s1_in_box_r <= {1'b0, row_r} < box_row_limit_r;
    end
  end

  // Peak update: first strict maximum among first pixels of even rows.
  pix_t   peak_nxt;
  coord_t peak_col_nxt, peak_row_nxt;
  always_comb begin
    if (!s1_row_r[0] && (s1_p1_r > peak_r)) begin
      peak_nxt     = s1_p1_r;
      peak_col_nxt = s1_col_r;
      peak_row_nxt = s1_row_r;
    end else begin
      peak_nxt     = peak_r;
      peak_col_nxt = peak_col_r;
      peak_row_nxt = peak_row_r;
    end
  end

  // Bounding box update: the first pixel is applied, then the second.
  logic   hit1, hit2;
  coord_t col_odd;
  logic   box_flag_nxt;
  coord_t box_left_nxt, box_right_nxt, box_top_nxt, box_bottom_nxt;
  always_comb begin
    hit1    = s1_in_box_r && (s1_p1_r > threshold_r);
    hit2    = s1_in_box_r && (s1_p2_r > threshold_r);
    col_odd = s1_col_r + coord_t'(1);
    box_flag_nxt   = box_flag_r;
    box_left_nxt   = box_left_r;
    box_right_nxt  = box_right_r;
    box_top_nxt    = box_top_r;
    box_bottom_nxt = box_bottom_r;
    if (hit1) begin
      if (!box_flag_nxt) begin
        box_flag_nxt   = 1'b1;
        box_left_nxt   = s1_col_r;
        box_right_nxt  = s1_col_r;
        box_top_nxt    = s1_row_r;
        box_bottom_nxt = s1_row_r;
      end else begin
        if (s1_col_r < box_left_nxt)   box_left_nxt   = s1_col_r;
        if (s1_col_r > box_right_nxt)  box_right_nxt  = s1_col_r;
        if (s1_row_r < box_top_nxt)    box_top_nxt    = s1_row_r;
        if (s1_row_r > box_bottom_nxt) box_bottom_nxt = s1_row_r;
      end
    end
    if (hit2) begin
      if (!box_flag_nxt) begin
        box_flag_nxt   = 1'b1;
        box_left_nxt   = col_odd;
        box_right_nxt  = col_odd;
        box_top_nxt    = s1_row_r;
        box_bottom_nxt = s1_row_r;
      end else begin
        if (col_odd < box_left_nxt)    box_left_nxt   = col_odd;
        if (col_odd > box_right_nxt)   box_right_nxt  = col_odd;
        if (s1_row_r < box_top_nxt)    box_top_nxt    = s1_row_r;
        if (s1_row_r > box_bottom_nxt) box_bottom_nxt = s1_row_r;
      end
    end
  end

  // Statistics state; the peak restarts after each frame, the box only at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r       <= '0;
      peak_col_r   <= '0;
      peak_row_r   <= '0;
      box_flag_r   <= 1'b0;
      box_left_r   <= '0;
      box_right_r  <= '0;
      box_top_r    <= '0;
      box_bottom_r <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        peak_r     <= '0;
        peak_col_r <= '0;
        peak_row_r <= '0;
      end else begin
        peak_r     <= peak_nxt;
        peak_col_r <= peak_col_nxt;
        peak_row_r <= peak_row_nxt;
      end
      box_flag_r   <= box_flag_nxt;
      box_left_r   <= box_left_nxt;
      box_right_r  <= box_right_nxt;
      box_top_r    <= box_top_nxt;
      box_bottom_r <= box_bottom_nxt;
    end
  end

  // Output register; statistics fields read zero except on the frame's last transaction.
  logic show_box;
  assign show_box = s1_last_r && box_flag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_pixel_even_r <= s1_p1_r;
      out_pixel_odd_r  <= s1_p2_r;
      out_frame_end_r  <= s1_last_r;
      out_peak_value_r <= s1_last_r ? peak_nxt     : '0;
      out_peak_col_r   <= s1_last_r ? peak_col_nxt : '0;
      out_peak_row_r   <= s1_last_r ? peak_row_nxt : '0;
      out_box_seen_r   <= show_box;
      out_box_left_r   <= show_box ? box_left_nxt   : '0;
      out_box_right_r  <= show_box ? box_right_nxt  : '0;
      out_box_top_r    <= show_box ? box_top_nxt    : '0;
      out_box_bottom_r <= show_box ? box_bottom_nxt : '0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.pixel_even = out_pixel_even_r;
  assign out_chan.pixel_odd  = out_pixel_odd_r;
  assign out_chan.frame_end  = out_frame_end_r;
  assign out_chan.peak_value = out_peak_value_r;
  assign out_chan.peak_col   = out_peak_col_r;
  assign out_chan.peak_row   = out_peak_row_r;
  assign out_chan.box_seen   = out_box_seen_r;
  assign out_chan.box_left   = out_box_left_r;
  assign out_chan.box_right  = out_box_right_r;
  assign out_chan.box_top    = out_box_top_r;
  assign out_chan.box_bottom = out_box_bottom_r;

  // The column counter moves two pixels at a time and so stays even.
  a_col_even: assert property (@(posedge clk) disable iff (!rst_n) !col_r[0])
    else $error("column counter is odd");

  // A reported peak of zero never carries a position.
  a_peak_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_peak_value_r == '0) |->
      (out_peak_col_r == '0) && (out_peak_row_r == '0))
    else $error("zero peak reported with a position");

  // A reported box is well ordered.
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_box_seen_r |->
      (out_box_left_r <= out_box_right_r) && (out_box_top_r <= out_box_bottom_r))
    else $error("bounding box corners out of order");

  // Once set, the box flag stays set until reset.
  a_box_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    box_flag_r |=> box_flag_r)
    else $error("box flag cleared without reset");

  // A transaction waiting in the correction stage moves on as soon as the output frees.
  a_s1_drains: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free && !in_take |=> !s1_valid_r && out_valid_r)
    else $error("correction stage failed to advance");

endmodule
